FILE: hw/rtl/point_rotate_project_macros.svh
// assertion macros for the point rotate and project block
// used by point_rotate_project.sv, needs aclk and aresetn in scope
`ifndef POINT_ROTATE_PROJECT_MACROS_SVH
`define POINT_ROTATE_PROJECT_MACROS_SVH

// same-cycle implication, checked out of reset
`define PRP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/prp_pkg.sv
// constants, register indexes and the quarter-wave sine table
// for the point rotate and project block; no dependencies
`default_nettype none

package prp_pkg;

    localparam int ANGLE_BITS = 10;
    localparam int COORD_BITS = 11;
    localparam int DIV_BITS   = 18;

    localparam logic [1:0] CFG_FOCAL_SCALE  = 2'd0;
    localparam logic [1:0] CFG_DEPTH_OFFSET = 2'd1;
    localparam logic [1:0] CFG_CENTER_X     = 2'd2;
    localparam logic [1:0] CFG_CENTER_Y     = 2'd3;

    localparam logic [9:0]  FOCAL_RESET  = 10'd200;
    localparam logic [11:0] OFFSET_RESET = 12'd900;
    localparam logic [11:0] CX_RESET     = 12'd80;
    localparam logic [11:0] CY_RESET     = 12'd250;

    localparam longint POLY0 = 64'sd1686629713;
    localparam longint POLY1 = -64'sd693598668;
    localparam longint POLY2 = 64'sd85569306;
    localparam longint POLY3 = -64'sd5026995;
    localparam longint POLY4 = 64'sd172272;

    typedef logic [14:0] sin_tab_t [256];

    // quarter-wave magnitudes, worked out at elaboration
    function automatic sin_tab_t build_sin_tab();
        sin_tab_t tab;
        longint   u;
        longint   u2;
        longint   r;
        longint   v;
        for (int i = 0; i < 256; i++) begin
            u  = longint'(i * 64) <<< 16;
            u2 = (u * u) >>> 30;
            r  = POLY4;
            r  = POLY3 + ((r * u2) >>> 30);
            r  = POLY2 + ((r * u2) >>> 30);
            r  = POLY1 + ((r * u2) >>> 30);
            r  = POLY0 + ((r * u2) >>> 30);
            v  = (((r * u) >>> 30) + 64'sd16384) >>> 15;
            if (v < 0) begin
                v = 0;
            end
            if (v > 32767) begin
                v = 32767;
            end
            tab[i] = v[14:0];
        end
        return tab;
    endfunction

    localparam sin_tab_t SIN_TAB = build_sin_tab();

    // sine of a phase in Q1.15, quadrant folding around the table
    function automatic logic signed [15:0] sin_q15(input logic [ANGLE_BITS-1:0] p);
        logic [8:0]  idx;
        logic [14:0] mag;
        idx = p[8] ? (9'd256 - {1'b0, p[7:0]}) : {1'b0, p[7:0]};
        mag = idx[8] ? 15'h7FFF : SIN_TAB[idx[7:0]];
        return p[9] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/point_rotate_project.sv
// point rotate and project block: three-axis rotation and perspective divide
// depends on prp_pkg and point_rotate_project_macros.svh
//
// One point per beat goes in, one projected point per beat comes out, and the
// block takes a new point on every clock while nothing downstream stalls. Each
// point passes 28 register stages: an input stage with the sine lookups, six
// stages for the three rotations (a multiply stage and an add-and-round stage
// per axis), a scale-and-offset stage, a setup stage and 18 restoring divider
// stages that give one quotient bit each, then the output register. The
// divider sets the latency. Valid bits travel with each stage and a stage
// moves on when the one after it is empty or moving, so bubbles close up and
// a stalled result holds while earlier points keep filling the pipe.
// Write the registers through the cfg port only while no point is in flight; the block does not enforce it.
`default_nettype none
`include "point_rotate_project_macros.svh"

module point_rotate_project import prp_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // point_x[10:0], point_y[21:11], point_z[32:22],
    // angle_a[42:33], angle_b[52:43], angle_c[62:53], zero pad
    input  wire logic [63:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // screen_x[15:0], screen_y[31:16], depth[43:32], zero pad
    output logic [47:0]      m_tdata,
    // behind[0]
    output logic [0:0]       m_tuser,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [11:0] cfg_data
);

    localparam int NSTG = 8 + DIV_BITS + 2;

    // stage payloads
    typedef struct packed {
        logic signed [10:0] x, y, z;
        logic signed [15:0] sa, ca, sb, cb, sc, cc;
    } st0_t;
    typedef struct packed {
        logic signed [26:0] p1, p2, p3, p4;
        logic signed [10:0] z;
        logic signed [15:0] sb, cb, sc, cc;
    } st1_t;
    typedef struct packed {
        logic signed [27:0] x1, y1;
        logic signed [10:0] z;
        logic signed [15:0] sb, cb, sc, cc;
    } st2_t;
    typedef struct packed {
        logic signed [26:0] zsb, zcb;
        logic signed [43:0] y1cb, y1sb;
        logic signed [27:0] x1;
        logic signed [15:0] sc, cc;
    } st3_t;
    typedef struct packed {
        logic signed [27:0] y2, z1, x1;
        logic signed [15:0] sc, cc;
    } st4_t;
    typedef struct packed {
        logic signed [43:0] z1cc, x1sc, z1sc, x1cc;
        logic signed [27:0] y2;
    } st5_t;
    typedef struct packed {
        logic signed [28:0] z2, x2;
        logic signed [27:0] y2;
    } st6_t;
    typedef struct packed {
        logic signed [39:0] nx, ny;
        logic signed [30:0] d;
        logic signed [11:0] dep;
        logic               behind;
    } st7_t;
    typedef struct packed {
        logic [47:0]         rx, ry;
        logic [30:0]         dv;
        logic [DIV_BITS-1:0] qx, qy;
        logic                sgx, sgy, ovx, ovy;
        logic signed [11:0]  dep;
        logic                behind;
    } div_t;

    // configuration registers
    logic [9:0]         focal_reg;
    logic [11:0]        offset_reg;
    logic signed [11:0] cx_reg, cy_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_reg  <= FOCAL_RESET;
            offset_reg <= OFFSET_RESET;
            cx_reg     <= CX_RESET;
            cy_reg     <= CY_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_FOCAL_SCALE:  focal_reg  <= cfg_data[9:0];
                CFG_DEPTH_OFFSET: offset_reg <= cfg_data;
                CFG_CENTER_X:     cx_reg     <= cfg_data;
                CFG_CENTER_Y:     cy_reg     <= cfg_data;
                default:          focal_reg  <= focal_reg;
            endcase
        end
    end

    // stage valid bits and bubble-closing advance enables
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] en;

    always_comb begin
        en[NSTG-1] = ~vld_reg[NSTG-1] | m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = ~vld_reg[k] | en[k+1];
        end
    end

    assign s_tready = en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // stage 0: unpack and sine lookups
    st0_t s0_reg, s0_next;
    always_comb begin
        s0_next.x  = s_tdata[10:0];
        s0_next.y  = s_tdata[21:11];
        s0_next.z  = s_tdata[32:22];
        s0_next.sa = sin_q15(s_tdata[42:33]);
        s0_next.ca = sin_q15(s_tdata[42:33] + 10'd256);
        s0_next.sb = sin_q15(s_tdata[52:43]);
        s0_next.cb = sin_q15(s_tdata[52:43] + 10'd256);
        s0_next.sc = sin_q15(s_tdata[62:53]);
        s0_next.cc = sin_q15(s_tdata[62:53] + 10'd256);
    end

    // stage 1: z-axis products
    st1_t s1_reg, s1_next;
    always_comb begin
        s1_next.p1 = s0_reg.x * s0_reg.ca;
        s1_next.p2 = s0_reg.y * s0_reg.sa;
        s1_next.p3 = s0_reg.x * s0_reg.sa;
        s1_next.p4 = s0_reg.y * s0_reg.ca;
        s1_next.z  = s0_reg.z;
        s1_next.sb = s0_reg.sb;
        s1_next.cb = s0_reg.cb;
        s1_next.sc = s0_reg.sc;
        s1_next.cc = s0_reg.cc;
    end

    // stage 2: x1, y1 in Q.15 (integer inputs make the rounding exact)
    st2_t s2_reg, s2_next;
    always_comb begin
        s2_next.x1 = 28'(s1_reg.p1) - 28'(s1_reg.p2);
        s2_next.y1 = 28'(s1_reg.p3) + 28'(s1_reg.p4);
        s2_next.z  = s1_reg.z;
        s2_next.sb = s1_reg.sb;
        s2_next.cb = s1_reg.cb;
        s2_next.sc = s1_reg.sc;
        s2_next.cc = s1_reg.cc;
    end

    // stage 3: second-axis products
    st3_t s3_reg, s3_next;
    always_comb begin
        s3_next.zsb  = s2_reg.z * s2_reg.sb;
        s3_next.zcb  = s2_reg.z * s2_reg.cb;
        s3_next.y1cb = s2_reg.y1 * s2_reg.cb;
        s3_next.y1sb = s2_reg.y1 * s2_reg.sb;
        s3_next.x1   = s2_reg.x1;
        s3_next.sc   = s2_reg.sc;
        s3_next.cc   = s2_reg.cc;
    end

    // stage 4: y2, z1 rounded half up back to Q.15
    st4_t s4_reg, s4_next;
    logic signed [44:0] y2_sum, z1_sum;
    always_comb begin
        y2_sum = (45'(s3_reg.zsb) <<< 15) - 45'(s3_reg.y1cb) + 45'sd16384;
        z1_sum = (45'(s3_reg.zcb) <<< 15) + 45'(s3_reg.y1sb) + 45'sd16384;
        s4_next.y2 = y2_sum[42:15];
        s4_next.z1 = z1_sum[42:15];
        s4_next.x1 = s3_reg.x1;
        s4_next.sc = s3_reg.sc;
        s4_next.cc = s3_reg.cc;
    end

    // stage 5: third-axis products
    st5_t s5_reg, s5_next;
    always_comb begin
        s5_next.z1cc = s4_reg.z1 * s4_reg.cc;
        s5_next.x1sc = s4_reg.x1 * s4_reg.sc;
        s5_next.z1sc = s4_reg.z1 * s4_reg.sc;
        s5_next.x1cc = s4_reg.x1 * s4_reg.cc;
        s5_next.y2   = s4_reg.y2;
    end

    // stage 6: z2, x2
    st6_t s6_reg, s6_next;
    logic signed [45:0] z2_sum, x2_sum;
    always_comb begin
        z2_sum = 46'(s5_reg.z1cc) - 46'(s5_reg.x1sc) + 46'sd16384;
        x2_sum = 46'(s5_reg.z1sc) + 46'(s5_reg.x1cc) + 46'sd16384;
        s6_next.z2 = z2_sum[43:15];
        s6_next.x2 = x2_sum[43:15];
        s6_next.y2 = s5_reg.y2;
    end

    // stage 7: focal scaling, divisor, depth and behind flag
    st7_t s7_reg, s7_next;
    logic signed [29:0] dep_sum;
    logic signed [14:0] dep_int;
    logic signed [10:0] focal_s;
    always_comb begin
        focal_s    = $signed({1'b0, focal_reg});
        s7_next.nx = s6_reg.x2 * focal_s;
        s7_next.ny = s6_reg.y2 * focal_s;
        s7_next.d  = 31'(s6_reg.z2) + $signed({4'b0, offset_reg, 15'b0});
        s7_next.behind = s7_next.d[30] | (s7_next.d == '0);
        dep_sum = 30'(s6_reg.z2) + 30'sd16384;
        dep_int = dep_sum[29:15];
        if (dep_int > 15'sd2047) begin
            s7_next.dep = 12'sd2047;
        end else if (dep_int < -15'sd2048) begin
            s7_next.dep = -12'sd2048;
        end else begin
            s7_next.dep = dep_int[11:0];
        end
    end

    // divider: setup then one quotient bit a stage
    div_t div_reg  [DIV_BITS+1];
    div_t div_next [DIV_BITS+1];
    logic [39:0] mag_x, mag_y;
    logic [47:0] dshift;

    always_comb begin
        mag_x  = s7_reg.nx[39] ? 40'(-s7_reg.nx) : 40'(s7_reg.nx);
        mag_y  = s7_reg.ny[39] ? 40'(-s7_reg.ny) : 40'(s7_reg.ny);
        // numerator 2*16*|n| + d, divisor 2*d: round half away from zero
        div_next[0].rx  = 48'({mag_x, 5'b0}) + 48'(s7_reg.d[29:0]);
        div_next[0].ry  = 48'({mag_y, 5'b0}) + 48'(s7_reg.d[29:0]);
        div_next[0].dv  = {s7_reg.d[29:0], 1'b0};
        dshift          = 48'(div_next[0].dv) << DIV_BITS;
        div_next[0].ovx = div_next[0].rx >= dshift;
        div_next[0].ovy = div_next[0].ry >= dshift;
        div_next[0].sgx = s7_reg.nx[39];
        div_next[0].sgy = s7_reg.ny[39];
        div_next[0].qx  = '0;
        div_next[0].qy  = '0;
        div_next[0].dep = s7_reg.dep;
        div_next[0].behind = s7_reg.behind;
    end

    for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
        localparam int BIT = DIV_BITS - 1 - k;
        logic [47:0] cmp;
        always_comb begin
            cmp         = 48'(div_reg[k].dv) << BIT;
            div_next[k+1] = div_reg[k];
            if (div_reg[k].rx >= cmp) begin
                div_next[k+1].rx      = div_reg[k].rx - cmp;
                div_next[k+1].qx[BIT] = 1'b1;
            end
            if (div_reg[k].ry >= cmp) begin
                div_next[k+1].ry      = div_reg[k].ry - cmp;
                div_next[k+1].qy[BIT] = 1'b1;
            end
        end
    end

    // output stage: sign, centre offset, saturation, behind masking
    function automatic logic signed [15:0] finish(
        input logic [DIV_BITS-1:0] q,
        input logic                sg,
        input logic                ov,
        input logic signed [11:0]  ctr
    );
        logic [DIV_BITS:0]         qm;
        logic signed [DIV_BITS+2:0] qs;
        logic signed [DIV_BITS+2:0] sum;
        qm  = ov ? (DIV_BITS+1)'(1) << DIV_BITS : {1'b0, q};
        qs  = sg ? -$signed((DIV_BITS+3)'(qm)) : $signed((DIV_BITS+3)'(qm));
        sum = qs + (DIV_BITS+3)'($signed({ctr, 4'b0}));
        if (sum > (DIV_BITS+3)'(32767)) begin
            return 16'sh7FFF;
        end else if (sum < -(DIV_BITS+3)'(32768)) begin
            return -16'sh8000;
        end
        return sum[15:0];
    endfunction

    logic [47:0] out_reg, out_next;
    logic        behind_reg;
    logic signed [15:0] sx_fin, sy_fin;

    always_comb begin
        sx_fin = finish(div_reg[DIV_BITS].qx, div_reg[DIV_BITS].sgx,
                        div_reg[DIV_BITS].ovx, cx_reg);
        sy_fin = finish(div_reg[DIV_BITS].qy, div_reg[DIV_BITS].sgy,
                        div_reg[DIV_BITS].ovy, cy_reg);
        if (div_reg[DIV_BITS].behind) begin
            sx_fin = '0;
            sy_fin = '0;
        end
        out_next = {4'b0, div_reg[DIV_BITS].dep, sy_fin, sx_fin};
    end

    // payload registers, loaded when their stage advances
    always_ff @(posedge aclk) begin
        if (en[0]) s0_reg <= s0_next;
        if (en[1]) s1_reg <= s1_next;
        if (en[2]) s2_reg <= s2_next;
        if (en[3]) s3_reg <= s3_next;
        if (en[4]) s4_reg <= s4_next;
        if (en[5]) s5_reg <= s5_next;
        if (en[6]) s6_reg <= s6_next;
        if (en[7]) s7_reg <= s7_next;
        for (int k = 0; k <= DIV_BITS; k++) begin
            if (en[8+k]) begin
                div_reg[k] <= div_next[k];
            end
        end
        if (en[NSTG-1]) begin
            out_reg    <= out_next;
            behind_reg <= div_reg[DIV_BITS].behind;
        end
    end

    assign m_tvalid   = vld_reg[NSTG-1];
    assign m_tdata    = out_reg;
    assign m_tuser[0] = behind_reg;

    // checks on the pipeline control and the behind masking
    `PRP_ASSERT_NOW(a_behind_zero, m_tvalid && m_tuser[0], m_tdata[31:0] == 32'd0,
                    "behind point with non-zero screen position")
    `PRP_ASSERT_NEXT(a_take_first, s_tvalid && s_tready, vld_reg[0],
                     "accepted beat missing from first stage")
    `PRP_ASSERT_NEXT(a_hold_stage, vld_reg[0] && !en[0], vld_reg[0],
                     "stalled first stage lost its beat")

endmodule

`default_nettype wire
